### src/subset_clear_parent_enumerator_assert.svh
// assertion macros used by the enumerator top level
`ifndef SUBSET_CLEAR_PARENT_ENUMERATOR_ASSERT_SVH
`define SUBSET_CLEAR_PARENT_ENUMERATOR_ASSERT_SVH

`ifndef ASSERT_OFF

// condition must hold at every clock edge outside reset
`define SCPE_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define SCPE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SCPE_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)

`define SCPE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

### src/scpe_pkg.sv
// shared constants and types of the subset-clear parent enumerator
package scpe_pkg;

   // fixed field widths
   localparam int IDX_W = 16;
   localparam int CNT_W = 5;

   // request modes
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_NEXT  = 1'b1;

   // control returned by the step logic
   typedef struct packed {
      logic             emit;
      logic             last;
      logic             busy_next;
      logic [CNT_W-1:0] clear_next;
   } step_ctl_type;

endpackage

### src/scpe_load.sv
// start logic: set bit count, rank positions and first keep mask of a new index
module scpe_load import scpe_pkg::*; #(
   parameter int RANK_W = 16,
   parameter int POS_W  = 4
) (
   input  logic [IDX_W-1:0]                cube_index,
   output logic [CNT_W-1:0]                set_count,
   output logic [RANK_W-1:0][POS_W-1:0]    rank_pos,
   output logic [RANK_W-1:0]               first_mask
);

   logic [RANK_W-1:0][CNT_W-1:0] below_cnt;
   logic [CNT_W-1:0]             total;

   // number of ranked set bits below each position, and in all
   always_comb begin
      total = '0;
      for (int b = 0; b < RANK_W; b++) begin
         below_cnt[b] = '0;
         for (int i = 0; i < b; i++) begin
            below_cnt[b] = below_cnt[b] + CNT_W'(cube_index[i]);
         end
         total = total + CNT_W'(cube_index[b]);
      end
   end

   assign set_count = total;

   // rank string position of each set bit, lowest set bit at the top
   always_comb begin
      for (int b = 0; b < RANK_W; b++) begin
         rank_pos[b] = POS_W'(total - CNT_W'(1) - below_cnt[b]);
      end
   end

   // first combination for one cleared bit: n-1 low ones
   always_comb begin
      for (int i = 0; i < RANK_W; i++) begin
         first_mask[i] = (CNT_W'(i) + CNT_W'(1)) < total;
      end
   end

endmodule

### src/scpe_step.sv
// next logic: parent deposit and same-popcount successor of the keep mask
module scpe_step import scpe_pkg::*; #(
   parameter int RANK_W = 16,
   parameter int POS_W  = 4
) (
   input  logic [IDX_W-1:0]                source_index,
   input  logic [CNT_W-1:0]                set_count,
   input  logic [RANK_W-1:0][POS_W-1:0]    rank_pos,
   input  logic [RANK_W-1:0]               keep_mask,
   input  logic [CNT_W-1:0]                clear_count,
   input  logic [CNT_W-1:0]                clear_limit,
   input  logic                            busy,
   output step_ctl_type                    ctl,
   output logic [IDX_W-1:0]                parent_index,
   output logic [RANK_W-1:0]               mask_next
);

   logic [CNT_W-1:0]  eff_k;
   logic [CNT_W-1:0]  next_k;
   logic [CNT_W-1:0]  next_eff;
   logic [RANK_W-1:0] final_mask;
   logic [RANK_W-1:0] first_next;
   logic [RANK_W-1:0] low_bit;
   logic [RANK_W-1:0] ripple;
   logic [RANK_W-1:0] gosper;
   logic [POS_W-1:0]  trail;
   logic              at_final;
   logic              done;

   // effective clear counts, capped at the set bit count
   assign eff_k    = (clear_count < set_count) ? clear_count : set_count;
   assign next_k   = clear_count + CNT_W'(1);
   assign next_eff = (next_k < set_count) ? next_k : set_count;

   // last combination of this k and first combination of the next k
   always_comb begin
      for (int i = 0; i < RANK_W; i++) begin
         final_mask[i] = (CNT_W'(i) >= eff_k) && (CNT_W'(i) < set_count);
         first_next[i] = (CNT_W'(i) + next_eff) < set_count;
      end
   end

   // trailing zero count of the keep mask
   always_comb begin
      trail = '0;
      for (int i = RANK_W - 1; i >= 0; i--) begin
         if (keep_mask[i]) begin
            trail = POS_W'(i);
         end
      end
   end

   // lexicographic successor with the same number of ones
   assign low_bit = keep_mask & (~keep_mask + RANK_W'(1));
   assign ripple  = keep_mask + low_bit;
   assign gosper  = (((ripple ^ keep_mask) >> 2) >> trail) | ripple;

   assign at_final  = (keep_mask == final_mask);
   assign done      = busy && at_final && (clear_count >= clear_limit);
   assign mask_next = at_final ? first_next : gosper;

   // control for the state registers
   always_comb begin
      ctl.emit       = busy;
      ctl.last       = done;
      ctl.busy_next  = busy && !done;
      ctl.clear_next = (busy && at_final && !done) ? next_k : clear_count;
   end

   // clear the set bits whose rank string entry is zero
   for (genvar b = 0; b < IDX_W; b++) begin : g_deposit
      if (b < RANK_W) begin : g_ranked
         assign parent_index[b] = source_index[b] & keep_mask[rank_pos[b]];
      end else begin : g_pass
         assign parent_index[b] = source_index[b];
      end
   end

endmodule

### src/subset_clear_parent_enumerator.sv
// top level of the subset-clear parent enumerator
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  mode, cube_index, max_cleared
//   rsp_      out        rsp_valid/rsp_ready  valid_res, parent_index, cleared_count, last
//
// one request per cycle unless a response stalls, one response per request, shown in the cycle after the accept
// start and next are both computed in the accept cycle into the response register
// req_ready is high while the response register is empty or being taken
// a stalled response holds the register and stalls requests
// synchronous reset clears the busy flag and the response valid

`include "subset_clear_parent_enumerator_assert.svh"

module subset_clear_parent_enumerator import scpe_pkg::*; #(
   parameter int DIMS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_mode,
   input  logic [IDX_W-1:0] req_cube_index,
   input  logic [CNT_W-1:0] req_max_cleared,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_valid_res,
   output logic [IDX_W-1:0] rsp_parent_index,
   output logic [CNT_W-1:0] rsp_cleared_count,
   output logic             rsp_last
);

   localparam int RANK_W = (DIMS < IDX_W) ? DIMS : IDX_W;
   localparam int POS_W  = (RANK_W > 1) ? $clog2(RANK_W) : 1;

   // enumeration state
   logic [IDX_W-1:0]             source_ff,  source_in;
   logic [CNT_W-1:0]             count_ff,   count_in;
   logic [RANK_W-1:0][POS_W-1:0] pos_ff,     pos_in;
   logic [RANK_W-1:0]            mask_ff,    mask_in;
   logic [CNT_W-1:0]             clear_ff,   clear_in;
   logic [CNT_W-1:0]             limit_ff,   limit_in;
   logic                         busy_ff,    busy_in;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         res_ff,       res_in;
   logic [IDX_W-1:0]             parent_ff,    parent_in;
   logic [CNT_W-1:0]             cnt_ff,       cnt_in;
   logic                         last_ff,      last_in;

   logic                         accept;
   logic                         is_start;
   logic                         emit;

   logic [CNT_W-1:0]             load_count;
   logic [RANK_W-1:0][POS_W-1:0] load_pos;
   logic [RANK_W-1:0]            load_mask;
   step_ctl_type                 step_ctl;
   logic [IDX_W-1:0]             step_parent;
   logic [RANK_W-1:0]            step_mask;

   // handshake
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_start  = (req_mode == MODE_START);
   assign emit      = !is_start && step_ctl.emit;

   scpe_load #(
      .RANK_W (RANK_W),
      .POS_W  (POS_W)
   ) u_load (
      .cube_index (req_cube_index),
      .set_count  (load_count),
      .rank_pos   (load_pos),
      .first_mask (load_mask)
   );

   scpe_step #(
      .RANK_W (RANK_W),
      .POS_W  (POS_W)
   ) u_step (
      .source_index (source_ff),
      .set_count    (count_ff),
      .rank_pos     (pos_ff),
      .keep_mask    (mask_ff),
      .clear_count  (clear_ff),
      .clear_limit  (limit_ff),
      .busy         (busy_ff),
      .ctl          (step_ctl),
      .parent_index (step_parent),
      .mask_next    (step_mask)
   );

   // next enumeration state
   always_comb begin
      source_in = source_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      mask_in   = mask_ff;
      clear_in  = clear_ff;
      limit_in  = limit_ff;
      busy_in   = busy_ff;
      if (accept && is_start) begin
         source_in = req_cube_index;
         count_in  = load_count;
         pos_in    = load_pos;
         mask_in   = load_mask;
         clear_in  = CNT_W'(1);
         limit_in  = req_max_cleared;
         busy_in   = (req_max_cleared != '0);
      end else if (accept && busy_ff) begin
         mask_in   = step_mask;
         clear_in  = step_ctl.clear_next;
         busy_in   = step_ctl.busy_next;
      end
   end

   // next response
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      res_in       = res_ff;
      parent_in    = parent_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         res_in       = emit;
         parent_in    = emit ? step_parent : '0;
         cnt_in       = emit ? clear_ff : '0;
         last_in      = emit && step_ctl.last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      source_ff <= source_in;
      count_ff  <= count_in;
      pos_ff    <= pos_in;
      mask_ff   <= mask_in;
      clear_ff  <= clear_in;
      limit_ff  <= limit_in;
      res_ff    <= res_in;
      parent_ff <= parent_in;
      cnt_ff    <= cnt_in;
      last_ff   <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_valid_res     = res_ff;
   assign rsp_parent_index  = parent_ff;
   assign rsp_cleared_count = cnt_ff;
   assign rsp_last          = last_ff;

   // checks
   `SCPE_ASSERT_ALWAYS(a_last_is_valid, clock, reset, !rsp_valid_ff || !last_ff || res_ff, "last flag on an empty response")
   `SCPE_ASSERT_ALWAYS(a_valid_has_count, clock, reset, !rsp_valid_ff || !res_ff || (cnt_ff != '0), "parent with zero cleared count")
   `SCPE_ASSERT_ALWAYS(a_busy_in_range, clock, reset, !busy_ff || ((clear_ff != '0) && (clear_ff <= limit_ff)), "clear count outside its limit while busy")
   `SCPE_ASSERT_NEXT(a_last_ends, clock, reset, accept && !is_start && busy_ff && step_ctl.last, !busy_ff, "enumeration continues after last parent")
   `SCPE_ASSERT_NEXT(a_start_loads, clock, reset, accept && is_start, (clear_ff == CNT_W'(1)) && (busy_ff == ($past(req_max_cleared) != '0)), "start did not load the first clear count")

endmodule

### dv/tb_subset_clear_parent_enumerator.sv
// self-checking testbench for the subset-clear parent enumerator
`timescale 1ns / 1ps

module tb_subset_clear_parent_enumerator;
   import scpe_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned RANDOM_REQUESTS = 1000;
   localparam int unsigned MAX_GAP = 18;

   // one request as queued for the driver
   typedef struct {
      logic             mode;
      logic [IDX_W-1:0] cube_index;
      logic [CNT_W-1:0] max_cleared;
      bit               drain;
      int unsigned      gap;
   } enum_req_type;

   // one response as predicted
   typedef struct packed {
      logic             valid_res;
      logic [IDX_W-1:0] parent_index;
      logic [CNT_W-1:0] cleared_count;
      logic             last;
   } parent_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_mode = MODE_START;
   logic [IDX_W-1:0] req_cube_index = '0;
   logic [CNT_W-1:0] req_max_cleared = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_valid_res;
   logic [IDX_W-1:0] rsp_parent_index;
   logic [CNT_W-1:0] rsp_cleared_count;
   logic             rsp_last;

   enum_req_type pending_reqs[$];
   parent_type   parents_due[$];
   int unsigned errors = 0;
   int unsigned cycles = 0;
   int unsigned starts_sent = 0;
   int unsigned nexts_sent = 0;
   int unsigned parents_seen = 0;
   int unsigned runs_finished = 0;
   bit          tx_quiet = 1'b0;

   // predictor state
   logic [IDX_W-1:0] enum_source = '0;
   int unsigned      enum_nbits = 0;
   int unsigned      enum_keep = 0;
   int unsigned      enum_k = 0;
   int unsigned      enum_limit = 0;
   bit               enum_busy = 1'b0;

   subset_clear_parent_enumerator u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_cube_index   (req_cube_index),
      .req_max_cleared  (req_max_cleared),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_valid_res    (rsp_valid_res),
      .rsp_parent_index (rsp_parent_index),
      .rsp_cleared_count(rsp_cleared_count),
      .rsp_last         (rsp_last)
   );

   always #4 clock = ~clock;

   function automatic int unsigned ones_in(logic [IDX_W-1:0] value);
      int unsigned n;
      n = 0;
      for (int b = 0; b < IDX_W; b++) n += value[b];
      return n;
   endfunction

   function automatic int unsigned low_ones(int unsigned w);
      return (32'd1 << w) - 1;
   endfunction

   // clear count in effect, capped at the number of set bits
   function automatic int unsigned eff_clear();
      return (enum_k < enum_nbits) ? enum_k : enum_nbits;
   endfunction

   // parents an enumeration yields before it runs dry
   function automatic int unsigned parents_total(int unsigned n, int unsigned limit);
      int unsigned binom;
      int unsigned total;
      binom = 1;
      total = 0;
      for (int unsigned k = 1; k <= limit; k++) begin
         if (k < n) begin
            binom = binom * (n - k + 1) / k;
            total += binom;
         end else begin
            total += 1;
         end
      end
      return total;
   endfunction

   // advance the enumeration by one request and return the expected response
   function automatic parent_type enumerate_step(logic mode, logic [IDX_W-1:0] cube_index,
                                                 logic [CNT_W-1:0] max_cleared);
      parent_type  res;
      logic [IDX_W-1:0] kept;
      int unsigned rank;
      int unsigned v;
      int unsigned c;
      int unsigned r;
      res = '0;
      if (mode == MODE_START) begin
         enum_source = cube_index;
         enum_nbits  = ones_in(cube_index);
         enum_limit  = max_cleared;
         enum_k      = 1;
         enum_keep   = low_ones(enum_nbits - eff_clear());
         enum_busy   = (enum_limit >= 1);
      end else if (enum_busy) begin
         // drop every set bit whose rank is marked cleared
         kept = enum_source;
         rank = 0;
         for (int b = 0; b < IDX_W; b++) begin
            if (enum_source[b]) begin
               if (!enum_keep[enum_nbits - 1 - rank]) kept[b] = 1'b0;
               rank++;
            end
         end
         res.valid_res     = 1'b1;
         res.parent_index  = kept;
         res.cleared_count = enum_k[CNT_W-1:0];
         if (enum_keep == (low_ones(enum_nbits - eff_clear()) << eff_clear())) begin
            if (enum_k >= enum_limit) begin
               res.last  = 1'b1;
               enum_busy = 1'b0;
            end else begin
               enum_k++;
               enum_keep = low_ones(enum_nbits - eff_clear());
            end
         end else begin
            // next mask with the same number of ones
            v = enum_keep;
            c = v & (~v + 1);
            r = v + c;
            if (c != 0) enum_keep = (((r ^ v) >> 2) / c) | r;
         end
      end
      return res;
   endfunction

   task automatic queue_req(logic mode, logic [IDX_W-1:0] cube_index,
                            logic [CNT_W-1:0] max_cleared, bit drain);
      enum_req_type item;
      if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
      item.mode        = mode;
      item.cube_index  = cube_index;
      item.max_cleared = max_cleared;
      item.drain       = drain;
      item.gap         = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      pending_reqs = {pending_reqs, item};
   endtask

   // next requests carry random payload, which the block must ignore
   task automatic queue_nexts(int unsigned count);
      for (int unsigned i = 0; i < count; i++)
         queue_req(MODE_NEXT, IDX_W'($urandom), CNT_W'($urandom), 1'b0);
   endtask

   // request driver
   bit           tx_fire;
   bit           tx_hold;
   bit           tx_armed = 1'b0;
   int unsigned  tx_wait = 0;
   enum_req_type tx_item;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_armed = 1'b0;
      end else begin
         tx_fire = req_valid && req_ready;
         if (tx_fire) begin
            parents_due = {parents_due,
                           enumerate_step(req_mode, req_cube_index, req_max_cleared)};
            if (req_mode == MODE_START) starts_sent++;
            else nexts_sent++;
         end
         tx_hold = req_valid && !tx_fire;
         if (!tx_hold && pending_reqs.size() > 0) begin
            if (!tx_armed) begin
               tx_wait  = pending_reqs[0].gap;
               tx_armed = 1'b1;
            end
            if (tx_wait > 0) begin
               tx_wait--;
            end else if (!pending_reqs[0].drain || (parents_due.size() == 0 && !tx_fire)) begin
               tx_item = pending_reqs.pop_front();
               req_mode        <= tx_item.mode;
               req_cube_index  <= tx_item.cube_index;
               req_max_cleared <= tx_item.max_cleared;
               tx_hold  = 1'b1;
               tx_armed = 1'b0;
            end
         end
         req_valid <= tx_hold;
      end
   end

   // response monitor and ready stalls
   parent_type  rx_want;
   int unsigned rx_wait = 0;
   bit          rx_quiet = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_wait = $urandom_range(0, MAX_GAP);
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (parents_due.size() == 0) begin
               $error("response with no request outstanding");
               errors++;
            end else begin
               rx_want = parents_due.pop_front();
               if (rsp_valid_res !== rx_want.valid_res) begin
                  $error("valid_res: expected %0d, got %0d", rx_want.valid_res, rsp_valid_res);
                  errors++;
               end
               if (rsp_parent_index !== rx_want.parent_index) begin
                  $error("parent_index: expected %h, got %h",
                         rx_want.parent_index, rsp_parent_index);
                  errors++;
               end
               if (rsp_cleared_count !== rx_want.cleared_count) begin
                  $error("cleared_count: expected %0d, got %0d",
                         rx_want.cleared_count, rsp_cleared_count);
                  errors++;
               end
               if (rsp_last !== rx_want.last) begin
                  $error("last: expected %0d, got %0d", rx_want.last, rsp_last);
                  errors++;
               end
               if (rx_want.valid_res) parents_seen++;
               if (rx_want.last) runs_finished++;
            end
            if ($urandom_range(0, 49) == 0) rx_quiet = !rx_quiet;
            rx_wait = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (rx_wait > 0) begin
            rx_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[subset_clear_parent_enumerator] ERROR");
         $finish;
      end
   end

   // stimulus and end of run
   logic [IDX_W-1:0] gen_index;
   int unsigned      gen_limit;
   int unsigned      gen_total;
   int unsigned      gen_nexts;
   int unsigned      gen_counted;
   initial begin
      // directed: idle next, full index, empty index, two-bit index, limit zero, drained start
      queue_nexts(1);
      queue_req(MODE_START, 16'hFFFF, 5'd16, 1'b0);
      queue_nexts(3);
      queue_req(MODE_START, 16'h0000, 5'd3, 1'b0);
      queue_nexts(4);
      queue_req(MODE_START, 16'h8001, 5'd4, 1'b0);
      queue_nexts(6);
      queue_req(MODE_START, 16'h00A5, 5'd0, 1'b0);
      queue_nexts(1);
      queue_req(MODE_START, 16'h0006, 5'd2, 1'b1);
      queue_nexts(3);

      // random enumerations, mostly sparse indexes and small limits
      gen_counted = 0;
      while (gen_counted < RANDOM_REQUESTS) begin
         case ($urandom_range(0, 5))
            0: gen_index = IDX_W'($urandom);
            1: gen_index = IDX_W'($urandom & $urandom);
            2: gen_index = IDX_W'($urandom & $urandom & $urandom);
            3: gen_index = IDX_W'(32'd1 << $urandom_range(0, IDX_W - 1));
            4: gen_index = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: gen_index = IDX_W'($urandom & $urandom & $urandom & $urandom);
         endcase
         gen_limit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 4);
         gen_total = parents_total(ones_in(gen_index), gen_limit);
         // mostly run to the end or past it, sometimes abandon midway
         if (gen_total <= 40 && $urandom_range(0, 3) != 0)
            gen_nexts = gen_total + $urandom_range(0, 2);
         else
            gen_nexts = $urandom_range(0, (gen_total < 40) ? gen_total : 40);
         queue_req(MODE_START, gen_index, CNT_W'(gen_limit), $urandom_range(0, 49) == 0);
         queue_nexts(gen_nexts);
         gen_counted += 1 + ((gen_nexts < gen_total) ? gen_nexts : gen_total);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid || parents_due.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("run covered %0d start and %0d next requests", starts_sent, nexts_sent);
      $display("%0d parents checked, %0d enumerations ran to their last parent",
               parents_seen, runs_finished);
      if (errors == 0) begin
         $display("[subset_clear_parent_enumerator] OK");
      end else begin
         $display("[subset_clear_parent_enumerator] ERROR");
      end
      $finish;
   end

endmodule
